// File: rtl/core/hrld_pkg.sv
// Shared types and constants for the HTTP request-line detector.
// Holds the method spelling table, protocol marker and the scan state struct.
// No dependencies.
package hrld_pkg;

   // Number of methods tracked and the longest method text, space included.
   localparam int unsigned METHOD_COUNT = 8;
   localparam int unsigned METHOD_MAX_LEN = 8;

   // Characters the scan looks for.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Five bytes preceding the slash of the protocol marker: " HTTP".
   localparam logic [39:0] PROTO_HEAD = 40'h20_48_54_54_50;

   // Lowest byte index at which the protocol marker may start.
   localparam int unsigned PROTO_START_MIN = 3;

   // Method text, one row per method, padded with zero bytes.
   localparam logic [7:0] METHOD_TEXT [0:7][0:7] = '{
      '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
      '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},  // POST
      '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},  // HEAD
      '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},  // PUT
      '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00},  // DELETE
      '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20},  // CONNECT
      '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h20},  // OPTIONS
      '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h00, 8'h00}   // PATCH
   };

   // Length of each method text including its trailing space.
   localparam logic [3:0] METHOD_LEN [0:7] = '{
      4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6
   };

   // Per-payload scan state, apart from the byte position.
   typedef struct packed {
      logic [7:0]  method_cand;   // methods still possible
      logic        method_hit;    // a whole method and its space were seen
      logic [39:0] window;        // last five bytes, newest lowest
      logic        proto_hit;     // protocol marker seen at an allowed index
      logic        str_end;       // terminator seen
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      method_cand: 8'hFF,
      method_hit:  1'b0,
      window:      40'h0,
      proto_hit:   1'b0,
      str_end:     1'b0
   };

endpackage

// File: rtl/core/hrld_scan.sv
// Next-state logic of the request-line scan for one payload byte.
// Uses hrld_pkg for the method table, protocol marker and state struct.
module hrld_scan #(
   parameter int unsigned SCAN_BYTES = 64,
   localparam int unsigned PW = $clog2(SCAN_BYTES + 1)
) (
   input  hrld_pkg::scan_state_type state_cur,
   input  logic [PW-1:0]            pos_cur,
   input  logic [7:0]               data_byte,
   output hrld_pkg::scan_state_type state_nxt,
   output logic [PW-1:0]            pos_nxt
);

   localparam logic [PW-1:0] POS_SCAN = PW'(SCAN_BYTES);
   localparam logic [PW-1:0] POS_TAKE_END = PW'(SCAN_BYTES - 1);
   localparam logic [PW-1:0] POS_METHOD_END = PW'(hrld_pkg::METHOD_MAX_LEN);
   localparam logic [PW-1:0] POS_PROTO_MIN = PW'(hrld_pkg::PROTO_START_MIN + 5);
   localparam logic [PW-1:0] POS_PROTO_MAX = PW'(SCAN_BYTES - 3);

   logic active;
   logic take;

   // A byte counts only before the terminator and inside the scan range.
   assign active = !state_cur.str_end && (pos_cur < POS_SCAN);
   assign take = active && (data_byte != hrld_pkg::CH_NUL) && (pos_cur < POS_TAKE_END);
   assign pos_nxt = active ? pos_cur + PW'(1) : pos_cur;

   // Terminator detection, method match, protocol marker and byte window update.
   always_comb begin
      logic [PW-1:0] len_pos;
      len_pos = '0;
      state_nxt = state_cur;
      if (active && (data_byte == hrld_pkg::CH_NUL)) begin
         state_nxt.str_end = 1'b1;
      end
      if (take) begin
         if (pos_cur < POS_METHOD_END) begin
            for (int m = 0; m < hrld_pkg::METHOD_COUNT; m++) begin
               len_pos = PW'(hrld_pkg::METHOD_LEN[m]);
               if (state_cur.method_cand[m] && (pos_cur < len_pos)) begin
                  if (data_byte != hrld_pkg::METHOD_TEXT[m][pos_cur[2:0]]) begin
                     state_nxt.method_cand[m] = 1'b0;
                  end else if (pos_cur + PW'(1) == len_pos) begin
                     state_nxt.method_hit = 1'b1;
                  end
               end
            end
         end
         if ((data_byte == hrld_pkg::CH_SLASH) && (state_cur.window == hrld_pkg::PROTO_HEAD)
             && (pos_cur >= POS_PROTO_MIN) && (pos_cur <= POS_PROTO_MAX)) begin
            state_nxt.proto_hit = 1'b1;
         end
         state_nxt.window = {state_cur.window[31:0], data_byte};
      end
   end

endmodule

// File: rtl/core/http_request_line_detect_core.sv
// HTTP request-line detector: one payload byte per beat, verdict on the last beat.
// A last beat passes the input register, then its verdict is loaded into the result register.
// Throughput: one byte per cycle when not stalled; the scan state updates once per accepted beat.
// The input stalls only when a last beat waits behind a stalled, full result register.
// Reset is synchronous and active high; it clears the scan state and both valid flags.
// Depends on hrld_pkg and hrld_scan.
module http_request_line_detect_core #(
   parameter int unsigned SCAN_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_request
);

   localparam int unsigned PW = $clog2(SCAN_BYTES + 1);

   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_data_ff;
   logic                     s1_last_ff;
   logic                     s1_go;
   logic                     req_take;
   hrld_pkg::scan_state_type state_ff, state_in, state_nxt;
   logic [PW-1:0]            pos_ff, pos_in, pos_nxt;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_data_ff;

   // The input stage moves on unless it holds a last beat and the result slot is blocked.
   assign s1_go = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take = req_valid && !req_stall;
   assign s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   hrld_scan #(
      .SCAN_BYTES(SCAN_BYTES)
   ) u_scan (
      .state_cur(state_ff),
      .pos_cur  (pos_ff),
      .data_byte(s1_data_ff),
      .state_nxt(state_nxt),
      .pos_nxt  (pos_nxt)
   );

   // Scan state advances per beat and returns to its reset value after a last beat.
   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            state_in = hrld_pkg::SCAN_STATE_RESET;
            pos_in = '0;
         end else begin
            state_in = state_nxt;
            pos_in = pos_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrld_pkg::SCAN_STATE_RESET;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
      end
   end

   // Result register: loaded by a last beat, held while stalled.
   assign rsp_valid_in = (s1_go && s1_last_ff) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= state_nxt.method_hit && state_nxt.proto_hit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_request = rsp_data_ff;

endmodule

// File: rtl/core/hrld_checker.sv
// Port-level checks for the HTTP request-line detector, with its bind.
// Depends only on the ports of http_request_line_detect_core.
module hrld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_request
);

   // The input is held back only by a blocked result beat.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result beat");

   // Coming out of reset nothing is pending on either side.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("activity right after reset");

   // A stalled input beat stays offered with the same payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_data_byte) && $stable(req_last_byte)))
      else $error("input beat changed while stalled");

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its verdict.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_is_request))
      else $error("result verdict changed while stalled");

endmodule

bind http_request_line_detect_core hrld_checker u_hrld_checker (.*);

// File: test/http_request_line_detect_core_test.sv
// Self-checking testbench for http_request_line_detect_core: drives payload beats, predicts
// each payload's request-line verdict and compares it with the block's result beats.
// Depends on hrld_pkg and the http_request_line_detect_core RTL.

// Tracks the scan state of the payload in flight and holds the verdicts still owed.
class request_line_scoreboard;
   int unsigned scan_len;
   int unsigned pos;
   logic [7:0]  cand;
   bit          method_seen;
   logic [39:0] tail;
   bit          marker_seen;
   bit          nul_seen;
   bit          verdict_q[$];
   int          mismatches;
   int          verdicts_noted;

   function new(int unsigned scan_len_in);
      scan_len = scan_len_in;
      mismatches = 0;
      verdicts_noted = 0;
      clear_scan();
   endfunction

   function void clear_scan();
      pos = 0;
      cand = 8'hFF;
      method_seen = 1'b0;
      tail = 40'h0;
      marker_seen = 1'b0;
      nul_seen = 1'b0;
   endfunction

   // Match one non-zero byte against the method table and close the protocol marker.
   function void take_char(logic [7:0] c);
      int unsigned start;
      if (pos < hrld_pkg::METHOD_MAX_LEN) begin
         for (int m = 0; m < hrld_pkg::METHOD_COUNT; m++) begin
            if (cand[m] && pos < hrld_pkg::METHOD_LEN[m]) begin
               if (c != hrld_pkg::METHOD_TEXT[m][pos]) begin
                  cand[m] = 1'b0;
               end else if (pos + 1 == hrld_pkg::METHOD_LEN[m]) begin
                  method_seen = 1'b1;
               end
            end
         end
      end
      // The slash completes " HTTP/" only if the marker started inside the allowed range.
      if (c == hrld_pkg::CH_SLASH && tail == hrld_pkg::PROTO_HEAD && pos >= 5) begin
         start = pos - 5;
         if (start >= hrld_pkg::PROTO_START_MIN && start + 8 <= scan_len) begin
            marker_seen = 1'b1;
         end
      end
      tail = {tail[31:0], c};
   endfunction

   // Account for one accepted input beat; a last beat owes one verdict.
   function void note_beat(logic [7:0] c, bit last);
      if (!nul_seen && pos < scan_len) begin
         if (c == hrld_pkg::CH_NUL) begin
            nul_seen = 1'b1;
         end else if (pos + 1 < scan_len) begin
            take_char(c);
         end
         pos++;
      end
      if (last) begin
         verdict_q.push_back(method_seen && marker_seen);
         verdicts_noted++;
         clear_scan();
      end
   endfunction

   // Compare one accepted result beat with the oldest verdict owed.
   function void check_verdict(logic is_request);
      bit want;
      if (verdict_q.size() == 0) begin
         $error("is_request: expected no result, actual %0b", is_request);
         mismatches++;
      end else begin
         want = verdict_q.pop_front();
         if (is_request !== want) begin
            $error("is_request: expected %0b, actual %0b", want, is_request);
            mismatches++;
         end
      end
   endfunction

   function int pending();
      return verdict_q.size();
   endfunction
endclass

module http_request_line_detect_core_test;
   localparam int unsigned SCAN_BYTES = 64;
   localparam int unsigned BEAT_TARGET = 750;
   localparam int unsigned VERDICT_TARGET = 40;
   localparam int unsigned IDLE_PCT = 21;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_is_request;

   request_line_scoreboard sb;
   logic [7:0]  payload_q[$];
   bit          calm;
   int unsigned beats_sent;
   int unsigned cycle_count;

   http_request_line_detect_core #(
      .SCAN_BYTES(SCAN_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_request(rsp_is_request)
   );

   // Clock with a 12-unit period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("http_request_line_detect_core verification failed");
         $finish;
      end
   end

   // Receiver back-pressure, off during the calm stretch.
   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Result beats are checked as they are accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_verdict(rsp_is_request);
      end
   end

   // Present one beat, with random idle cycles ahead of it, and wait until it is taken.
   task automatic drive_beat(logic [7:0] c, bit last);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= c;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      sb.note_beat(c, last);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_payload();
      for (int i = 0; i < payload_q.size(); i++) begin
         drive_beat(payload_q[i], i == payload_q.size() - 1);
      end
      payload_q.delete();
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         payload_q.push_back(s[i]);
      end
   endtask

   task automatic push_method(int m, int n);
      for (int i = 0; i < n; i++) begin
         payload_q.push_back(hrld_pkg::METHOD_TEXT[m][i]);
      end
   endtask

   // Hold the input idle until every owed verdict has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Mostly well-formed request lines with random content, then near misses and noise.
   task automatic build_random_payload();
      int kind;
      int m;
      int len;
      int s;
      int n;
      int idx;
      kind = $urandom_range(0, 99);
      m = $urandom_range(0, hrld_pkg::METHOD_COUNT - 1);
      len = hrld_pkg::METHOD_LEN[m];
      if (kind < 65) begin
         push_method(m, len);
         // Marker start: usually near the method, sometimes around the end of its window.
         if ($urandom_range(0, 9) == 0) s = $urandom_range(48, 60);
         else s = len - 1 + $urandom_range(0, 5);
         if (s < len) begin
            push_text("HTTP/");
         end else begin
            repeat (s - len) payload_q.push_back(8'($urandom_range(1, 255)));
            push_text(" HTTP/");
         end
         // Tail, occasionally long enough to run past the scan limit.
         if ($urandom_range(0, 11) == 0) n = $urandom_range(40, 70);
         else n = $urandom_range(0, 4);
         repeat (n) payload_q.push_back(8'($urandom_range(1, 255)));
         // Damage a byte or cut the payload short now and then.
         if ($urandom_range(0, 99) < 15) begin
            idx = $urandom_range(0, payload_q.size() - 1);
            payload_q[idx] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, payload_q.size());
            while (payload_q.size() > n) void'(payload_q.pop_back());
         end
      end else if (kind < 80) begin
         // A method prefix, possibly cut short, then the marker with or without its leading space.
         push_method(m, $urandom_range(1, len));
         if ($urandom_range(0, 1) == 1) push_text(" HTTP/");
         else push_text("HTTP/");
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      rsp_stall = 1'b0;
      calm = 1'b0;
      beats_sent = 0;
      cycle_count = 0;
      sb = new(SCAN_BYTES);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Marker sharing the method's space, at the lowest allowed start.
      push_text("GET HTTP/");
      send_payload();
      // A lone terminator and a lone all-ones byte.
      payload_q.push_back(hrld_pkg::CH_NUL);
      send_payload();
      payload_q.push_back(8'hFF);
      send_payload();
      // Payload shorter than its method.
      push_text("PUT");
      send_payload();
      // Marker after the terminator is ignored.
      push_text("GET ");
      payload_q.push_back(hrld_pkg::CH_NUL);
      push_text("HTTP/");
      send_payload();
      drain_results();

      // Random payloads, with a calm stretch and one more full drain midway.
      for (int p = 0; beats_sent < BEAT_TARGET || sb.verdicts_noted < VERDICT_TARGET; p++) begin
         calm = (p >= 12 && p < 22);
         if (p == 30) drain_results();
         build_random_payload();
         send_payload();
      end
      calm = 1'b0;

      // Wait for the remaining verdicts, then keep watching for stray results.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("http_request_line_detect_core verification clean");
      end else begin
         $display("http_request_line_detect_core verification failed");
      end
      $finish;
   end

endmodule
